// ===== hw/rtl/sset_pkg.sv =====
// ----------------------------------------------------------------------------
// Sensor settling detector package
// Shared widths, register map, payload types, state codes and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package sset_pkg;

   // field widths
   localparam int TDS_W = 17;
   localparam int PH_W  = 14;
   localparam int RUN_W = 4;

   // default geometry
   localparam int WINDOW_SAMPLES_DEF  = 30;
   localparam int HISTORY_WINDOWS_DEF = 30;
   localparam int SPREAD_WINDOWS_DEF  = 7;

   // register file
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [TDS_W-1:0] TDS_ALL_ONES = '1;
   localparam logic [PH_W-1:0]  PH_ALL_ONES  = '1;

   localparam logic [TDS_W-1:0] TDS_WINDOW_LIMIT_RST  = TDS_W'(100);
   localparam logic [PH_W-1:0]  PH_WINDOW_LIMIT_RST   = PH_W'(60);
   localparam logic [PH_W-1:0]  PH_HISTORY_LIMIT_RST  = PH_W'(70);
   localparam logic [TDS_W-1:0] TDS_HISTORY_LIMIT_RST = TDS_W'(128);
   localparam logic [PH_W-1:0]  PH_AVERAGE_LIMIT_RST  = PH_W'(20);
   localparam logic [TDS_W-1:0] TDS_AVERAGE_LIMIT_RST = TDS_W'(26);
   localparam logic [RUN_W-1:0] REQUIRED_STABLE_RST   = RUN_W'(4);

   typedef enum logic [2:0] {
      REG_TDS_WINDOW_LIMIT  = 3'd0,
      REG_PH_WINDOW_LIMIT   = 3'd1,
      REG_PH_HISTORY_LIMIT  = 3'd2,
      REG_TDS_HISTORY_LIMIT = 3'd3,
      REG_PH_AVERAGE_LIMIT  = 3'd4,
      REG_TDS_AVERAGE_LIMIT = 3'd5,
      REG_REQUIRED_STABLE   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [TDS_W-1:0] tds_window_limit;
      logic [PH_W-1:0]  ph_window_limit;
      logic [PH_W-1:0]  ph_history_limit;
      logic [TDS_W-1:0] tds_history_limit;
      logic [PH_W-1:0]  ph_average_limit;
      logic [TDS_W-1:0] tds_average_limit;
      logic [RUN_W-1:0] required_stable;
   } csr_type;

   typedef struct packed {
      logic [TDS_W-1:0] tds_sample;
      logic [PH_W-1:0]  ph_sample;
   } req_type;

   typedef struct packed {
      logic             window_stable;
      logic             settled;
      logic             history_restart;
      logic [RUN_W-1:0] stable_run;
      logic [TDS_W-1:0] tds_average;
      logic [PH_W-1:0]  ph_average;
   } rsp_type;

   // one stored window
   typedef struct packed {
      logic [TDS_W-1:0] tds_high;
      logic [TDS_W-1:0] tds_low;
      logic [PH_W-1:0]  ph_high;
      logic [PH_W-1:0]  ph_low;
      logic [TDS_W-1:0] tds_avg;
      logic [PH_W-1:0]  ph_avg;
   } hist_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_DIVIDE = 3'd1,
      ST_STORE  = 3'd2,
      ST_WALK   = 3'd3,
      ST_REPORT = 3'd4
   } state_type;

   typedef struct packed {
      logic sample_load;
      logic div_step;
      logic store;
      logic walk;
      logic report;
   } ctrl_cmd_type;

   typedef struct packed {
      logic window_end;
      logic div_last;
      logic hist_full;
      logic need_walk;
      logic walk_last;
      logic out_free;
   } dp_status_type;

endpackage

// ===== hw/rtl/sensor_settling_detector_top.sv =====
// ----------------------------------------------------------------------------
// Sensor settling detector top level
// Groups conductivity and pH samples into windows, tracks window history and
// reports per window whether the readings have settled.
// ----------------------------------------------------------------------------
// A sample that does not close a window is taken without a stall. After the sample
// that closes a window is taken, req_stall stays high while the controller steps
// through its states in order: the divide step forms both averages by a reciprocal
// multiply, the store step stores the window, the walk over the recent windows
// reads the history memory one entry a cycle, and the report step reports.
// While the history is too short to walk, or is full, the walk is skipped. The
// report step also waits while the previous result is still held in the output
// register. A finished result waits in the output register while intake goes on.
// The history memory needs no clearing pass after reset.
module sensor_settling_detector_top
   import sset_pkg::*;
#(
   parameter int WINDOW_SAMPLES  = WINDOW_SAMPLES_DEF,
   parameter int HISTORY_WINDOWS = HISTORY_WINDOWS_DEF,
   parameter int SPREAD_WINDOWS  = SPREAD_WINDOWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   csr_type       csr;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   sset_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .csr     (csr)
   );

   sset_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sset_dp #(
      .WINDOW_SAMPLES  (WINDOW_SAMPLES),
      .HISTORY_WINDOWS (HISTORY_WINDOWS),
      .SPREAD_WINDOWS  (SPREAD_WINDOWS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr       (csr),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/sset_csr.sv =====
// ----------------------------------------------------------------------------
// Sensor settling detector register file
// APB-style write and read access to the seven limit registers.
// ----------------------------------------------------------------------------
module sset_csr
   import sset_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output csr_type               csr
);

   csr_type       csr_ff, csr_in;
   reg_index_type index;
   logic          write_en;

   assign index    = reg_index_type'(paddr[4:2]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign csr      = csr_ff;

   // decode the write word into the addressed register
   always_comb begin
      csr_in = csr_ff;
      if (write_en) begin
         case (index)
            REG_TDS_WINDOW_LIMIT:  csr_in.tds_window_limit  = pwdata[TDS_W-1:0];
            REG_PH_WINDOW_LIMIT:   csr_in.ph_window_limit   = pwdata[PH_W-1:0];
            REG_PH_HISTORY_LIMIT:  csr_in.ph_history_limit  = pwdata[PH_W-1:0];
            REG_TDS_HISTORY_LIMIT: csr_in.tds_history_limit = pwdata[TDS_W-1:0];
            REG_PH_AVERAGE_LIMIT:  csr_in.ph_average_limit  = pwdata[PH_W-1:0];
            REG_TDS_AVERAGE_LIMIT: csr_in.tds_average_limit = pwdata[TDS_W-1:0];
            REG_REQUIRED_STABLE:   csr_in.required_stable   = pwdata[RUN_W-1:0];
            default:               csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.tds_window_limit  <= TDS_WINDOW_LIMIT_RST;
         csr_ff.ph_window_limit   <= PH_WINDOW_LIMIT_RST;
         csr_ff.ph_history_limit  <= PH_HISTORY_LIMIT_RST;
         csr_ff.tds_history_limit <= TDS_HISTORY_LIMIT_RST;
         csr_ff.ph_average_limit  <= PH_AVERAGE_LIMIT_RST;
         csr_ff.tds_average_limit <= TDS_AVERAGE_LIMIT_RST;
         csr_ff.required_stable   <= REQUIRED_STABLE_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // read back the addressed register
   always_comb begin
      case (index)
         REG_TDS_WINDOW_LIMIT:  prdata = CSR_DATA_W'(csr_ff.tds_window_limit);
         REG_PH_WINDOW_LIMIT:   prdata = CSR_DATA_W'(csr_ff.ph_window_limit);
         REG_PH_HISTORY_LIMIT:  prdata = CSR_DATA_W'(csr_ff.ph_history_limit);
         REG_TDS_HISTORY_LIMIT: prdata = CSR_DATA_W'(csr_ff.tds_history_limit);
         REG_PH_AVERAGE_LIMIT:  prdata = CSR_DATA_W'(csr_ff.ph_average_limit);
         REG_TDS_AVERAGE_LIMIT: prdata = CSR_DATA_W'(csr_ff.tds_average_limit);
         REG_REQUIRED_STABLE:   prdata = CSR_DATA_W'(csr_ff.required_stable);
         default:               prdata = '0;
      endcase
   end

endmodule

// ===== hw/rtl/sset_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sensor settling detector controller
// Sequences sample intake, average division, history store, history walk and
// the result report.
// ----------------------------------------------------------------------------
module sset_ctrl
   import sset_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.window_end) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_STORE;
         end
         ST_STORE: begin
            if (status.hist_full)      state_in = ST_REPORT;
            else if (status.need_walk) state_in = ST_WALK;
            else                       state_in = ST_REPORT;
         end
         ST_WALK: begin
            if (status.walk_last) state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall       = 1'b0;
            cmd.sample_load = req_valid;
         end
         ST_DIVIDE: cmd.div_step = 1'b1;
         ST_STORE:  cmd.store    = 1'b1;
         ST_WALK:   cmd.walk     = 1'b1;
         ST_REPORT: cmd.report   = status.out_free;
         default:   cmd          = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/sset_dp.sv =====
// ----------------------------------------------------------------------------
// Sensor settling detector datapath
// Window accumulators, reciprocal divider for the averages, window history
// memory, history walk and the result register.
// ----------------------------------------------------------------------------
module sset_dp
   import sset_pkg::*;
#(
   parameter int WINDOW_SAMPLES  = WINDOW_SAMPLES_DEF,
   parameter int HISTORY_WINDOWS = HISTORY_WINDOWS_DEF,
   parameter int SPREAD_WINDOWS  = SPREAD_WINDOWS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  req_type       req_data,
   input  csr_type       csr,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   output rsp_type       rsp_data
);

   localparam int CW    = $clog2(WINDOW_SAMPLES);
   localparam int TSW   = TDS_W + CW;
   localparam int PSW   = PH_W + CW;
   localparam int DS    = TSW + CW;
   localparam int PW    = 2 * TSW + 1;
   localparam int RECIP = (2**DS + WINDOW_SAMPLES - 1) / WINDOW_SAMPLES;
   localparam int HA    = $clog2(HISTORY_WINDOWS);
   localparam int HC    = $clog2(HISTORY_WINDOWS + 1);
   localparam int WKW   = $clog2(SPREAD_WINDOWS + 1);

   // window accumulators
   logic [CW-1:0]    cnt_ff;
   logic [TDS_W-1:0] tds_low_ff, tds_high_ff, tds_low_in, tds_high_in;
   logic [PH_W-1:0]  ph_low_ff, ph_high_ff, ph_low_in, ph_high_in;
   logic [TSW-1:0]   tds_sum_ff, tds_sum_in;
   logic [PSW-1:0]   ph_sum_ff, ph_sum_in;

   // window snapshot
   logic [TDS_W-1:0] w_tds_low_ff, w_tds_high_ff;
   logic [PH_W-1:0]  w_ph_low_ff, w_ph_high_ff;

   // divider lanes
   logic [TSW-1:0]   tq_ff, pq_ff, tq_in, pq_in;
   logic [PW-1:0]    tprod, pprod;

   // history
   hist_type         mem [HISTORY_WINDOWS];
   hist_type         wr_entry, rd_data_ff;
   logic [HC-1:0]    stored_ff;
   logic [HC:0]      stored_inc;
   logic [HC-1:0]    raddr_full;
   logic [WKW-1:0]   wk_ff;
   logic             rd_vld_ff;
   logic             restart_ff, check_ff;

   // walk extrema and running average bounds
   logic [TDS_W-1:0] tmax_ff, tmin_ff, avg_tds_max_ff, avg_tds_min_ff;
   logic [PH_W-1:0]  pmax_ff, pmin_ff, avg_ph_max_ff, avg_ph_min_ff;
   logic [RUN_W-1:0] stable_ff, stable_inc;
   logic             ok, settle;

   // result register
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   // fold the incoming sample into the window
   always_comb begin
      tds_low_in  = (req_data.tds_sample < tds_low_ff)  ? req_data.tds_sample : tds_low_ff;
      tds_high_in = (req_data.tds_sample > tds_high_ff) ? req_data.tds_sample : tds_high_ff;
      ph_low_in   = (req_data.ph_sample < ph_low_ff)    ? req_data.ph_sample  : ph_low_ff;
      ph_high_in  = (req_data.ph_sample > ph_high_ff)   ? req_data.ph_sample  : ph_high_ff;
      tds_sum_in  = tds_sum_ff + TSW'(req_data.tds_sample);
      ph_sum_in   = ph_sum_ff + PSW'(req_data.ph_sample);
   end

   // divide by the window length: multiply by the rounded-up reciprocal and
   // shift, exact for every sum that fits the accumulator
   always_comb begin
      tprod = PW'(tq_ff) * PW'(RECIP);
      pprod = PW'(pq_ff) * PW'(RECIP);
      tq_in = TSW'(tprod >> DS);
      pq_in = TSW'(pprod >> DS);
   end

   // history bookkeeping
   always_comb begin
      stored_inc = {1'b0, stored_ff} + (HC+1)'(1);
      raddr_full = stored_ff - HC'(SPREAD_WINDOWS) + HC'(wk_ff);
      wr_entry.tds_high = w_tds_high_ff;
      wr_entry.tds_low  = w_tds_low_ff;
      wr_entry.ph_high  = w_ph_high_ff;
      wr_entry.ph_low   = w_ph_low_ff;
      wr_entry.tds_avg  = tq_ff[TDS_W-1:0];
      wr_entry.ph_avg   = pq_ff[PH_W-1:0];
   end

   // stability decision
   always_comb begin
      stable_inc = stable_ff + RUN_W'(1);
      ok = !restart_ff && check_ff
         && ((w_tds_high_ff - w_tds_low_ff) <= csr.tds_window_limit)
         && ((w_ph_high_ff - w_ph_low_ff) <= csr.ph_window_limit)
         && ((avg_ph_max_ff - avg_ph_min_ff) <= csr.ph_average_limit)
         && ((pmax_ff - pmin_ff) <= csr.ph_history_limit)
         && ((tmax_ff - tmin_ff) <= csr.tds_history_limit)
         && ((avg_tds_max_ff - avg_tds_min_ff) <= csr.tds_average_limit);
      settle = ok && (stable_inc >= csr.required_stable);
   end

   // the reciprocal product needs a single divide step
   assign status.window_end = cnt_ff == CW'(WINDOW_SAMPLES - 1);
   assign status.div_last   = 1'b1;
   assign status.hist_full  = stored_ff >= HC'(HISTORY_WINDOWS);
   assign status.need_walk  = stored_inc > (HC+1)'(SPREAD_WINDOWS);
   assign status.walk_last  = (wk_ff == WKW'(SPREAD_WINDOWS)) && rd_vld_ff;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // window accumulators and long-lived state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff         <= '0;
         tds_low_ff     <= TDS_ALL_ONES;
         tds_high_ff    <= '0;
         ph_low_ff      <= PH_ALL_ONES;
         ph_high_ff     <= '0;
         tds_sum_ff     <= '0;
         ph_sum_ff      <= '0;
         stored_ff      <= '0;
         stable_ff      <= '0;
         avg_tds_max_ff <= '0;
         avg_tds_min_ff <= TDS_ALL_ONES;
         avg_ph_max_ff  <= '0;
         avg_ph_min_ff  <= PH_ALL_ONES;
         restart_ff     <= 1'b0;
         check_ff       <= 1'b0;
         wk_ff          <= '0;
         rd_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // take a sample; close the window on its last one
         if (cmd.sample_load) begin
            if (status.window_end) begin
               cnt_ff      <= '0;
               tds_low_ff  <= TDS_ALL_ONES;
               tds_high_ff <= '0;
               ph_low_ff   <= PH_ALL_ONES;
               ph_high_ff  <= '0;
               tds_sum_ff  <= '0;
               ph_sum_ff   <= '0;
            end else begin
               cnt_ff      <= cnt_ff + CW'(1);
               tds_low_ff  <= tds_low_in;
               tds_high_ff <= tds_high_in;
               ph_low_ff   <= ph_low_in;
               ph_high_ff  <= ph_high_in;
               tds_sum_ff  <= tds_sum_in;
               ph_sum_ff   <= ph_sum_in;
            end
         end

         // append the window or flag a restart
         if (cmd.store) begin
            restart_ff <= status.hist_full;
            check_ff   <= !status.hist_full && status.need_walk;
            if (!status.hist_full) begin
               stored_ff <= stored_inc[HC-1:0];
            end
            wk_ff     <= '0;
            rd_vld_ff <= 1'b0;
         end

         // walk the most recent windows, one entry a cycle
         if (cmd.walk) begin
            if (wk_ff < WKW'(SPREAD_WINDOWS)) begin
               wk_ff     <= wk_ff + WKW'(1);
               rd_vld_ff <= 1'b1;
            end else begin
               rd_vld_ff <= 1'b0;
            end
            if (rd_vld_ff) begin
               if (rd_data_ff.ph_avg < avg_ph_min_ff)   avg_ph_min_ff  <= rd_data_ff.ph_avg;
               if (rd_data_ff.ph_avg > avg_ph_max_ff)   avg_ph_max_ff  <= rd_data_ff.ph_avg;
               if (rd_data_ff.tds_avg < avg_tds_min_ff) avg_tds_min_ff <= rd_data_ff.tds_avg;
               if (rd_data_ff.tds_avg > avg_tds_max_ff) avg_tds_max_ff <= rd_data_ff.tds_avg;
            end
         end

         // drop the result once taken
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         // report and update the stable run
         if (cmd.report) begin
            rsp_valid_ff <= 1'b1;
            if (restart_ff || settle) begin
               stored_ff      <= '0;
               stable_ff      <= '0;
               avg_tds_max_ff <= '0;
               avg_tds_min_ff <= TDS_ALL_ONES;
               avg_ph_max_ff  <= '0;
               avg_ph_min_ff  <= PH_ALL_ONES;
            end else if (ok) begin
               stable_ff <= stable_inc;
            end else begin
               stable_ff <= '0;
            end
         end
      end
   end

   // snapshot, divider lanes, walk extrema and result payload
   always_ff @(posedge clock) begin
      if (cmd.sample_load && status.window_end) begin
         w_tds_low_ff  <= tds_low_in;
         w_tds_high_ff <= tds_high_in;
         w_ph_low_ff   <= ph_low_in;
         w_ph_high_ff  <= ph_high_in;
         tq_ff         <= tds_sum_in;
         pq_ff         <= TSW'(ph_sum_in);
      end else if (cmd.div_step) begin
         tq_ff <= tq_in;
         pq_ff <= pq_in;
      end

      if (cmd.store) begin
         tmax_ff <= '0;
         tmin_ff <= TDS_ALL_ONES;
         pmax_ff <= '0;
         pmin_ff <= PH_ALL_ONES;
      end else if (cmd.walk && rd_vld_ff) begin
         if (rd_data_ff.tds_high > tmax_ff) tmax_ff <= rd_data_ff.tds_high;
         if (rd_data_ff.tds_low < tmin_ff)  tmin_ff <= rd_data_ff.tds_low;
         if (rd_data_ff.ph_high > pmax_ff)  pmax_ff <= rd_data_ff.ph_high;
         if (rd_data_ff.ph_low < pmin_ff)   pmin_ff <= rd_data_ff.ph_low;
      end

      if (cmd.report) begin
         rsp_data_ff.window_stable   <= ok;
         rsp_data_ff.settled         <= settle;
         rsp_data_ff.history_restart <= restart_ff;
         rsp_data_ff.stable_run      <= ok ? stable_inc : '0;
         rsp_data_ff.tds_average     <= tq_ff[TDS_W-1:0];
         rsp_data_ff.ph_average      <= pq_ff[PH_W-1:0];
      end
   end

   // history memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.store && !status.hist_full) begin
         mem[stored_ff[HA-1:0]] <= wr_entry;
      end
      if (cmd.walk && (wk_ff < WKW'(SPREAD_WINDOWS))) begin
         rd_data_ff <= mem[raddr_full[HA-1:0]];
      end
   end

endmodule

// ===== hw/rtl/sset_checker.sv =====
// ----------------------------------------------------------------------------
// Sensor settling detector port checker
// Watches the result channel for consistent flags and stable held words.
// ----------------------------------------------------------------------------
module sset_checker
   import sset_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // settled only on a stable window
   a_settle_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.settled |-> rsp_data.window_stable)
      else $error("settled reported on an unstable window");

   // restart carries no decision
   a_restart_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.history_restart |->
         !rsp_data.window_stable && !rsp_data.settled && (rsp_data.stable_run == '0))
      else $error("restart word carries a decision");

   // unstable window clears the run
   a_unstable_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.window_stable |-> rsp_data.stable_run == '0)
      else $error("unstable window with nonzero run");

   // hold a stalled word
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sensor_settling_detector_top sset_checker u_sset_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== verif/tb_sensor_settling_detector_top.sv =====
// ----------------------------------------------------------------------------
// Sensor settling detector testbench
// Drives paired conductivity and pH words through the valid/stall request
// channel, predicts each window result in a scoreboard class and checks every
// response word field by field. Thresholds are rewritten over the APB port
// between phases while the block is idle, and in some phases both sides idle at random.
// ----------------------------------------------------------------------------
module tb_sensor_settling_detector_top;
   import sset_pkg::*;

   localparam int WINDOW   = WINDOW_SAMPLES_DEF;
   localparam int HISTORY  = HISTORY_WINDOWS_DEF;
   localparam int SPREAD   = SPREAD_WINDOWS_DEF;
   localparam int DRAIN    = 48;
   localparam int HANG_MAX = 4000;
   localparam int TDS_TOP  = 100000;
   localparam int PH_TOP   = 14000;

   // window predictor and store of expected window results
   class settle_scoreboard;
      logic [TDS_W-1:0] lim_tds_win, lim_tds_hist, lim_tds_avg;
      logic [PH_W-1:0]  lim_ph_win, lim_ph_hist, lim_ph_avg;
      logic [RUN_W-1:0] need_stable;
      int unsigned      n_samples;
      logic [TDS_W-1:0] w_tds_lo, w_tds_hi;
      logic [PH_W-1:0]  w_ph_lo, w_ph_hi;
      logic [21:0]      tds_acc;
      logic [18:0]      ph_acc;
      hist_type         windows[HISTORY];
      int unsigned      n_windows;
      logic [TDS_W-1:0] avg_tds_lo, avg_tds_hi;
      logic [PH_W-1:0]  avg_ph_lo, avg_ph_hi;
      logic [RUN_W-1:0] run_len;
      rsp_type          expected_results[$];
      int               errors;

      function new();
         lim_tds_win  = TDS_WINDOW_LIMIT_RST;
         lim_ph_win   = PH_WINDOW_LIMIT_RST;
         lim_ph_hist  = PH_HISTORY_LIMIT_RST;
         lim_tds_hist = TDS_HISTORY_LIMIT_RST;
         lim_ph_avg   = PH_AVERAGE_LIMIT_RST;
         lim_tds_avg  = TDS_AVERAGE_LIMIT_RST;
         need_stable  = REQUIRED_STABLE_RST;
         errors       = 0;
         clear_all();
      endfunction

      function void clear_window();
         n_samples = 0;
         w_tds_lo  = TDS_ALL_ONES;
         w_tds_hi  = '0;
         w_ph_lo   = PH_ALL_ONES;
         w_ph_hi   = '0;
         tds_acc   = '0;
         ph_acc    = '0;
      endfunction

      function void clear_all();
         clear_window();
         n_windows  = 0;
         avg_tds_lo = TDS_ALL_ONES;
         avg_tds_hi = '0;
         avg_ph_lo  = PH_ALL_ONES;
         avg_ph_hi  = '0;
         run_len    = '0;
      endfunction

      function void write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_TDS_WINDOW_LIMIT:  lim_tds_win  = val[TDS_W-1:0];
            REG_PH_WINDOW_LIMIT:   lim_ph_win   = val[PH_W-1:0];
            REG_PH_HISTORY_LIMIT:  lim_ph_hist  = val[PH_W-1:0];
            REG_TDS_HISTORY_LIMIT: lim_tds_hist = val[TDS_W-1:0];
            REG_PH_AVERAGE_LIMIT:  lim_ph_avg   = val[PH_W-1:0];
            REG_TDS_AVERAGE_LIMIT: lim_tds_avg  = val[TDS_W-1:0];
            REG_REQUIRED_STABLE:   need_stable  = val[RUN_W-1:0];
            default: ;
         endcase
      endfunction

      // fold one accepted sample in; a closing sample queues one result
      function void note_sample(req_type s);
         rsp_type          r;
         hist_type         h;
         logic [TDS_W-1:0] tmax, tmin;
         logic [PH_W-1:0]  pmax, pmin;
         logic             ok;
         if (s.tds_sample < w_tds_lo) w_tds_lo = s.tds_sample;
         if (s.tds_sample > w_tds_hi) w_tds_hi = s.tds_sample;
         if (s.ph_sample < w_ph_lo) w_ph_lo = s.ph_sample;
         if (s.ph_sample > w_ph_hi) w_ph_hi = s.ph_sample;
         tds_acc += s.tds_sample;
         ph_acc  += s.ph_sample;
         n_samples++;
         if (n_samples < WINDOW) return;

         r = '0;
         r.tds_average = TDS_W'(tds_acc / WINDOW);
         r.ph_average  = PH_W'(ph_acc / WINDOW);
         h.tds_high = w_tds_hi;
         h.tds_low  = w_tds_lo;
         h.ph_high  = w_ph_hi;
         h.ph_low   = w_ph_lo;
         h.tds_avg  = r.tds_average;
         h.ph_avg   = r.ph_average;
         clear_window();

         if (n_windows >= HISTORY) begin
            // full history: restart without a decision
            clear_all();
            r.history_restart = 1'b1;
         end else begin
            ok = 1'b0;
            windows[n_windows] = h;
            n_windows++;
            if (n_windows > SPREAD) begin
               tmax = '0;
               tmin = TDS_ALL_ONES;
               pmax = '0;
               pmin = PH_ALL_ONES;
               for (int k = n_windows - SPREAD; k < n_windows; k++) begin
                  if (windows[k].tds_high > tmax) tmax = windows[k].tds_high;
                  if (windows[k].tds_low < tmin) tmin = windows[k].tds_low;
                  if (windows[k].ph_high > pmax) pmax = windows[k].ph_high;
                  if (windows[k].ph_low < pmin) pmin = windows[k].ph_low;
                  if (windows[k].ph_avg < avg_ph_lo) avg_ph_lo = windows[k].ph_avg;
                  if (windows[k].ph_avg > avg_ph_hi) avg_ph_hi = windows[k].ph_avg;
                  if (windows[k].tds_avg < avg_tds_lo) avg_tds_lo = windows[k].tds_avg;
                  if (windows[k].tds_avg > avg_tds_hi) avg_tds_hi = windows[k].tds_avg;
               end
               ok = (h.tds_high - h.tds_low) <= lim_tds_win
                 && (h.ph_high - h.ph_low) <= lim_ph_win
                 && (avg_ph_hi - avg_ph_lo) <= lim_ph_avg
                 && (pmax - pmin) <= lim_ph_hist
                 && (tmax - tmin) <= lim_tds_hist
                 && (avg_tds_hi - avg_tds_lo) <= lim_tds_avg;
            end
            if (!ok) begin
               run_len = '0;
            end else begin
               r.window_stable = 1'b1;
               run_len++;
               r.stable_run = run_len;
               if (run_len >= need_stable) begin
                  r.settled = 1'b1;
                  clear_all();
               end
            end
         end
         expected_results.push_back(r);
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: result word with none expected, got %h", $time, got);
            return;
         end
         want = expected_results.pop_front();
         compare_field("window_stable", want.window_stable, got.window_stable);
         compare_field("settled", want.settled, got.settled);
         compare_field("history_restart", want.history_restart, got.history_restart);
         compare_field("stable_run", want.stable_run, got.stable_run);
         compare_field("tds_average", want.tds_average, got.tds_average);
         compare_field("ph_average", want.ph_average, got.ph_average);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   settle_scoreboard sb = new();
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               hang_cycles = 0;
   int unsigned      sent_count = 0;
   int               tds_center = 5000;
   int               ph_center = 7000;
   int               noisy_window = 0;

   sensor_settling_detector_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // check result words and draw the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // drop the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
         hang_cycles <= 0;
      else
         hang_cycles <= hang_cycles + 1;
      if (hang_cycles >= HANG_MAX) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_W-1:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      sb.write_reg(idx, val);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic send_word(logic [TDS_W-1:0] tds, logic [PH_W-1:0] ph);
      req_type w;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      w.tds_sample = tds;
      w.ph_sample  = ph;
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      sb.note_sample(w);
      sent_count++;
   endtask

   // quiet windows sit near a center; noisy ones roam the whole field
   task automatic run_samples(int count, int noisy_pct, int move_pct);
      int t, p;
      repeat (count) begin
         if (sent_count % WINDOW == 0) begin
            noisy_window = ($urandom_range(0, 99) < noisy_pct);
            if ($urandom_range(0, 99) < move_pct) begin
               tds_center = $urandom_range(0, TDS_TOP - 20);
               ph_center  = $urandom_range(0, PH_TOP - 10);
            end
         end
         if (noisy_window) begin
            if ($urandom_range(0, 4) == 0) begin
               t = $urandom_range(0, 2**TDS_W - 1);
               p = $urandom_range(0, 2**PH_W - 1);
            end else begin
               t = $urandom_range(0, TDS_TOP);
               p = $urandom_range(0, PH_TOP);
            end
         end else begin
            t = tds_center + $urandom_range(0, 20);
            p = ph_center + $urandom_range(0, 10);
         end
         send_word(TDS_W'(t), PH_W'(p));
      end
      req_valid <= 1'b0;
   endtask

   // wait out every expected word, then the DRAIN margin
   task automatic drain();
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles lightly, receiver heavily; reset thresholds
      send_idle_pct = 24;
      recv_idle_pct = 76;
      send_word('0, '0);
      send_word(TDS_W'(TDS_TOP), PH_W'(PH_TOP));
      send_word(TDS_ALL_ONES, PH_ALL_ONES);
      send_word(TDS_W'(17'h15555), PH_W'(14'h1555));
      send_word(TDS_W'(17'h0AAAA), PH_W'(14'h2AAA));
      send_word('0, PH_ALL_ONES);
      send_word(TDS_ALL_ONES, '0);
      run_samples(263, 15, 5);
      drain();

      // zero thresholds, settle on one: noise never passes, history fills
      send_idle_pct = 76;
      recv_idle_pct = 24;
      csr_write(REG_TDS_WINDOW_LIMIT, '0);
      csr_write(REG_PH_WINDOW_LIMIT, '0);
      csr_write(REG_PH_HISTORY_LIMIT, '0);
      csr_write(REG_TDS_HISTORY_LIMIT, '0);
      csr_write(REG_PH_AVERAGE_LIMIT, '0);
      csr_write(REG_TDS_AVERAGE_LIMIT, '0);
      csr_write(REG_REQUIRED_STABLE, 1);
      run_samples(900, 100, 0);
      drain();

      // widest thresholds, zero run: any checked window that passes settles
      send_idle_pct = 0;
      recv_idle_pct = 0;
      csr_write(REG_TDS_WINDOW_LIMIT, TDS_TOP);
      csr_write(REG_PH_WINDOW_LIMIT, PH_TOP);
      csr_write(REG_PH_HISTORY_LIMIT, PH_TOP);
      csr_write(REG_TDS_HISTORY_LIMIT, TDS_TOP);
      csr_write(REG_PH_AVERAGE_LIMIT, PH_TOP);
      csr_write(REG_TDS_AVERAGE_LIMIT, TDS_TOP);
      csr_write(REG_REQUIRED_STABLE, '0);
      run_samples(180, 30, 20);
      drain();

      // default thresholds with the longest run
      csr_write(REG_TDS_WINDOW_LIMIT, CSR_DATA_W'(TDS_WINDOW_LIMIT_RST));
      csr_write(REG_PH_WINDOW_LIMIT, CSR_DATA_W'(PH_WINDOW_LIMIT_RST));
      csr_write(REG_PH_HISTORY_LIMIT, CSR_DATA_W'(PH_HISTORY_LIMIT_RST));
      csr_write(REG_TDS_HISTORY_LIMIT, CSR_DATA_W'(TDS_HISTORY_LIMIT_RST));
      csr_write(REG_PH_AVERAGE_LIMIT, CSR_DATA_W'(PH_AVERAGE_LIMIT_RST));
      csr_write(REG_TDS_AVERAGE_LIMIT, CSR_DATA_W'(TDS_AVERAGE_LIMIT_RST));
      csr_write(REG_REQUIRED_STABLE, 15);
      run_samples(600, 5, 2);
      drain();

      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
